>>> rtl/core/fwm_pkg.sv
// Package for the frame window multiplier: widths, window and register codes,
// cosine-sum coefficients, the quarter-wave cosine ROM builder and the control structs.
// No dependencies.
`default_nettype none

package fwm_pkg;

    // Field and datapath widths
    localparam int SAMPLE_W    = 24;
    localparam int NSZ_W       = 13;
    localparam int POS_W       = 12;
    localparam int ALPHA_W     = 17;
    localparam int WIN_W       = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 17;
    localparam int MAX_FRAME   = 4096;
    localparam int COS_DEPTH   = 1024;
    localparam int ROM_AW      = 11;
    localparam int TURN_W      = 12;
    localparam int ROMW_W      = 17;
    localparam int COS_W       = 18;
    localparam int WEIGHT_W    = 19;
    localparam int COEF_W      = 30;
    localparam int QUO_W       = 14;
    localparam int DVD_W       = 42;
    localparam int DVS_W       = 30;
    localparam int DEN_W       = 29;
    localparam int PROD_W      = 48;
    localparam int ACC_W       = 51;
    localparam int OPROD_W     = 43;
    localparam int ONE_Q16     = 65536;
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

    typedef logic        [SAMPLE_W-1:0]   samp_u_t;
    typedef logic signed [SAMPLE_W-1:0]   samp_t;
    typedef logic        [NSZ_W-1:0]      nsz_t;
    typedef logic        [POS_W-1:0]      pos_t;
    typedef logic        [ALPHA_W-1:0]    alpha_t;
    typedef logic        [WIN_W-1:0]      win_t;
    typedef logic        [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic        [CFG_DATA_W-1:0] cfg_data_t;
    typedef logic        [ROM_AW-1:0]     rom_addr_t;
    typedef logic        [TURN_W-1:0]     turn_t;
    typedef logic        [ROMW_W-1:0]     romw_t;
    typedef logic signed [COS_W-1:0]      cos_t;
    typedef logic signed [WEIGHT_W-1:0]   weight_t;
    typedef logic        [COEF_W-1:0]     coef_t;
    typedef logic        [QUO_W-1:0]      quo_t;
    typedef logic        [DVD_W-1:0]      dvd_t;
    typedef logic        [DVS_W-1:0]      dvs_t;
    typedef logic        [DEN_W-1:0]      den_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [ACC_W-1:0]      acc_t;
    typedef logic signed [OPROD_W-1:0]    oprod_t;
    typedef romw_t cos_rom_t [0:COS_DEPTH];

    // Window type codes; 6 and 7 fall back to rectangular
    localparam win_t WIN_RECT    = 3'd0;
    localparam win_t WIN_HANN    = 3'd1;
    localparam win_t WIN_HAMMING = 3'd2;
    localparam win_t WIN_BH      = 3'd3;
    localparam win_t WIN_FLAT    = 3'd4;
    localparam win_t WIN_TUKEY   = 3'd5;

    // Configuration register indexes
    localparam cfg_idx_t REG_WINDOW_TYPE = 2'd0;
    localparam cfg_idx_t REG_FRAME_SIZE  = 2'd1;
    localparam cfg_idx_t REG_TUKEY_ALPHA = 2'd2;

    typedef enum logic [1:0] {
        CLASS_RECT,
        CLASS_COS,
        CLASS_TUKEY
    } win_class_t;

    typedef struct packed {
        logic accept;
        logic rom_zero;
        logic rom_from_q;
        logic div_cos;
        logic tuk_prep;
        logic tuk_div;
        logic mul;
        logic acc;
        logic cos_w;
        logic tuk_w;
        logic one_w;
        logic out_mul;
        logic out_load;
    } fwm_cmd_t;

    typedef struct packed {
        win_class_t win_class;
        logic       k_zero;
        logic       k_last;
        logic       div_done;
        logic       div_busy;
        logic       tuk_flat;
        logic       out_free;
    } fwm_sts_t;

    // Cosine-sum coefficient k of a window, Q30
    function automatic coef_t win_coef(win_t wt, logic [2:0] k);
        coef_t c;
        c = '0;
        case (wt)
            WIN_HANN:    c = coef_t'(30'd536870912);
            WIN_HAMMING: c = (k == 3'd0) ? coef_t'(30'd579820585) : coef_t'(30'd493921239);
            WIN_BH:
            begin
                case (k)
                    3'd0:    c = coef_t'(30'd385204879);
                    3'd1:    c = coef_t'(30'd524297395);
                    3'd2:    c = coef_t'(30'd151698245);
                    default: c = coef_t'(30'd12541305);
                endcase
            end
            WIN_FLAT:
            begin
                case (k)
                    3'd0:    c = coef_t'(30'd231476135);
                    3'd1:    c = coef_t'(30'd447354753);
                    3'd2:    c = coef_t'(30'd297709049);
                    3'd3:    c = coef_t'(30'd89742211);
                    default: c = coef_t'(30'd7459680);
                endcase
            end
            default:     c = '0;
        endcase
        return c;
    endfunction

    // Number of cosine terms of a window
    function automatic logic [2:0] win_terms(win_t wt);
        logic [2:0] t;
        case (wt)
            WIN_HANN:    t = 3'd2;
            WIN_HAMMING: t = 3'd2;
            WIN_BH:      t = 3'd4;
            WIN_FLAT:    t = 3'd5;
            default:     t = 3'd1;
        endcase
        return t;
    endfunction

    // Quarter-wave cosine table, Q16, from an 8-term Taylor series in Q30
    function automatic cos_rom_t build_cos_rom();
        cos_rom_t           t;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        acc_u;
        logic signed [63:0] acc;
        for (int i = 0; i <= COS_DEPTH; i++)
        begin
            x    = (64'(i) * PI_HALF_Q30) / COS_DEPTH;
            x2   = (x * x) >> 30;
            term = 64'd1 << 30;
            acc  = $signed(term);
            term = ((term * x2) >> 30) / 64'd2;
            acc  = acc - $signed(term);
            term = ((term * x2) >> 30) / 64'd12;
            acc  = acc + $signed(term);
            term = ((term * x2) >> 30) / 64'd30;
            acc  = acc - $signed(term);
            term = ((term * x2) >> 30) / 64'd56;
            acc  = acc + $signed(term);
            term = ((term * x2) >> 30) / 64'd90;
            acc  = acc - $signed(term);
            term = ((term * x2) >> 30) / 64'd132;
            acc  = acc + $signed(term);
            term = ((term * x2) >> 30) / 64'd182;
            acc  = acc - $signed(term);
            if (acc < 0)
            begin
                acc = 0;
            end
            acc_u = ($unsigned(acc) + 64'd8192) >> 14;
            if (acc_u > 64'(ONE_Q16))
            begin
                acc_u = 64'(ONE_Q16);
            end
            t[i] = romw_t'(acc_u);
        end
        return t;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/fwm_sample_if.sv
// Input sample channel: valid/ready handshake carrying one signed sample per beat.
// Depends on fwm_pkg.
`default_nettype none

interface fwm_sample_if;
    logic           valid;
    logic           ready;
    fwm_pkg::samp_t sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

>>> rtl/core/fwm_result_if.sv
// Result channel: valid/ready handshake carrying the windowed sample and frame flag.
// Depends on fwm_pkg.
`default_nettype none

interface fwm_result_if;
    logic           valid;
    logic           ready;
    fwm_pkg::samp_t windowed_sample;
    logic           last_of_frame;

    modport source (output valid, output windowed_sample, output last_of_frame, input ready);
    modport sink   (input valid, input windowed_sample, input last_of_frame, output ready);
endinterface

`default_nettype wire

>>> rtl/core/fwm_cfg_if.sv
// Configuration write channel: valid/ready handshake carrying register index and data.
// Depends on fwm_pkg.
`default_nettype none

interface fwm_cfg_if;
    logic                valid;
    logic                ready;
    fwm_pkg::cfg_idx_t   index;
    fwm_pkg::cfg_data_t  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/fwm_divider.sv
// Restoring divider, one quotient bit per cycle, QUO_W bits of quotient.
// Depends on fwm_pkg; the dividend must stay below divisor * 2^QUO_W.
`default_nettype none

module fwm_divider (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire fwm_pkg::dvd_t dividend,
    input  wire fwm_pkg::dvs_t divisor,
    output logic               busy,
    output logic               done,
    output fwm_pkg::quo_t      quotient
);

    localparam int REM_W = fwm_pkg::DVS_W + fwm_pkg::QUO_W - 1;
    localparam int CNT_W = $clog2(fwm_pkg::QUO_W + 1);

    logic [REM_W-1:0] rem_reg;
    logic [REM_W-1:0] dsh_reg;
    fwm_pkg::quo_t    quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             fits;

    assign fits = (rem_reg >= dsh_reg);

    // Control: count the quotient steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(fwm_pkg::QUO_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: subtract the shifted divisor where it fits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= REM_W'(dividend);
            dsh_reg <= {divisor, {(fwm_pkg::QUO_W - 1){1'b0}}};
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            quo_reg <= {quo_reg[fwm_pkg::QUO_W-2:0], fits};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

>>> rtl/core/fwm_cos_rom.sv
// Full-turn cosine lookup over a quarter-wave ROM with registered read, signed Q16 out.
// Depends on fwm_pkg (table contents and widths).
`default_nettype none

module fwm_cos_rom (
    input  wire logic           clk,
    input  wire logic           rd_en,
    input  wire fwm_pkg::turn_t phase,
    output fwm_pkg::cos_t       cos_val
);

    localparam fwm_pkg::cos_rom_t COS_ROM = fwm_pkg::build_cos_rom();

    logic [1:0]          quad;
    logic [9:0]          frac;
    fwm_pkg::rom_addr_t  addr;
    logic                neg;
    fwm_pkg::romw_t      data_reg;
    logic                neg_reg;

    // Fold the phase into the first quadrant
    assign quad = phase[fwm_pkg::TURN_W-1 -: 2];
    assign frac = phase[9:0];
    assign addr = quad[0] ? (fwm_pkg::rom_addr_t'(fwm_pkg::COS_DEPTH) - fwm_pkg::rom_addr_t'(frac))
                          : fwm_pkg::rom_addr_t'(frac);
    assign neg  = quad[1] ^ quad[0];

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            data_reg <= COS_ROM[addr];
            neg_reg  <= neg;
        end
    end

    assign cos_val = neg_reg ? -fwm_pkg::cos_t'(data_reg) : fwm_pkg::cos_t'(data_reg);

endmodule

`default_nettype wire

>>> rtl/core/fwm_ctrl.sv
// Sequencer for the frame window multiplier: steps terms, divider, ROM and output.
// Depends on fwm_pkg (command and status structs).
`default_nettype none

module fwm_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire fwm_pkg::fwm_sts_t sts,
    output fwm_pkg::fwm_cmd_t      cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TERM,
        ST_DIVW,
        ST_ROMW,
        ST_ACC,
        ST_CWEIGHT,
        ST_TPREP,
        ST_TCHECK,
        ST_ONEW,
        ST_OMUL,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Decode commands and next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    case (sts.win_class)
                        fwm_pkg::CLASS_COS:   state_next = ST_TERM;
                        fwm_pkg::CLASS_TUKEY: state_next = ST_TPREP;
                        default:              state_next = ST_ONEW;
                    endcase
                end
            end
            ST_TERM:
            begin
                if (sts.k_zero)
                begin
                    cmd.rom_zero = 1'b1;
                    state_next   = ST_ROMW;
                end
                else
                begin
                    cmd.div_cos = 1'b1;
                    state_next  = ST_DIVW;
                end
            end
            ST_DIVW:
            begin
                if (sts.div_done)
                begin
                    cmd.rom_from_q = 1'b1;
                    state_next     = ST_ROMW;
                end
            end
            ST_ROMW:
            begin
                if (sts.win_class == fwm_pkg::CLASS_TUKEY)
                begin
                    cmd.tuk_w  = 1'b1;
                    state_next = ST_OMUL;
                end
                else
                begin
                    cmd.mul    = 1'b1;
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = sts.k_last ? ST_CWEIGHT : ST_TERM;
            end
            ST_CWEIGHT:
            begin
                cmd.cos_w  = 1'b1;
                state_next = ST_OMUL;
            end
            ST_TPREP:
            begin
                cmd.tuk_prep = 1'b1;
                state_next   = ST_TCHECK;
            end
            ST_TCHECK:
            begin
                if (sts.tuk_flat)
                begin
                    state_next = ST_ONEW;
                end
                else
                begin
                    cmd.tuk_div = 1'b1;
                    state_next  = ST_DIVW;
                end
            end
            ST_ONEW:
            begin
                cmd.one_w  = 1'b1;
                state_next = ST_OMUL;
            end
            ST_OMUL:
            begin
                cmd.out_mul = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

>>> rtl/core/fwm_datapath.sv
// Datapath: configuration registers, frame position, phase divider, cosine ROM,
// coefficient MAC, Tukey taper and the saturating output multiply. Depends on fwm_pkg,
// fwm_divider and fwm_cos_rom.
`default_nettype none

module fwm_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire fwm_pkg::fwm_cmd_t  cmd,
    output fwm_pkg::fwm_sts_t       sts,
    input  wire fwm_pkg::samp_t     sample,
    input  wire logic               cfg_wr,
    input  wire fwm_pkg::cfg_idx_t  cfg_index,
    input  wire fwm_pkg::cfg_data_t cfg_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output fwm_pkg::samp_t          out_sample,
    output logic                    out_last
);

    localparam fwm_pkg::oprod_t SAT_MAX = fwm_pkg::oprod_t'((64'sd1 <<< (fwm_pkg::SAMPLE_W - 1)) - 1);
    localparam fwm_pkg::oprod_t SAT_MIN = -SAT_MAX - fwm_pkg::oprod_t'(1);

    fwm_pkg::win_t    wtype_reg;
    fwm_pkg::nsz_t    fsize_reg;
    fwm_pkg::alpha_t  alpha_reg;
    fwm_pkg::pos_t    pos_reg;
    fwm_pkg::pos_t    n_reg;
    fwm_pkg::samp_t   samp_reg;
    logic [2:0]       k_reg;
    fwm_pkg::prod_t   prod_reg;
    fwm_pkg::acc_t    acc_reg;
    fwm_pkg::den_t    den_reg;
    fwm_pkg::weight_t w_reg;
    fwm_pkg::oprod_t  oprod_reg;
    logic             out_valid_reg;
    fwm_pkg::samp_t   out_sample_reg;
    logic             out_last_reg;

    fwm_pkg::nsz_t        eff_n;
    fwm_pkg::alpha_t      alpha_c;
    fwm_pkg::win_class_t  win_class;
    logic [2:0]           n_terms;
    logic [14:0]          kn;
    fwm_pkg::dvd_t        cos_dvd;
    fwm_pkg::dvs_t        cos_dvs;
    fwm_pkg::den_t        np;
    fwm_pkg::dvs_t        flat_lim;
    logic                 tuk_first;
    logic                 tuk_flat;
    fwm_pkg::nsz_t        tuk_d;
    fwm_pkg::dvd_t        tuk_dvd;
    fwm_pkg::dvs_t        tuk_dvs;
    logic                 div_start;
    logic                 div_busy;
    logic                 div_done;
    fwm_pkg::quo_t        quotient;
    logic                 rom_en;
    fwm_pkg::turn_t       rom_phase;
    fwm_pkg::cos_t        cos_val;
    fwm_pkg::oprod_t      rnd;
    fwm_pkg::samp_t       sat;
    logic                 out_free;
    logic                 last_pos;
    fwm_pkg::nsz_t        n_inc;

    // Clamp frame size and alpha, classify the window
    always_comb
    begin
        if (fsize_reg == '0)
        begin
            eff_n = fwm_pkg::nsz_t'(1);
        end
        else if (fsize_reg > fwm_pkg::nsz_t'(fwm_pkg::MAX_FRAME))
        begin
            eff_n = fwm_pkg::nsz_t'(fwm_pkg::MAX_FRAME);
        end
        else
        begin
            eff_n = fsize_reg;
        end
        alpha_c = (alpha_reg > fwm_pkg::alpha_t'(fwm_pkg::ONE_Q16))
                  ? fwm_pkg::alpha_t'(fwm_pkg::ONE_Q16) : alpha_reg;
        case (wtype_reg)
            fwm_pkg::WIN_HANN,
            fwm_pkg::WIN_HAMMING,
            fwm_pkg::WIN_BH,
            fwm_pkg::WIN_FLAT:  win_class = fwm_pkg::CLASS_COS;
            fwm_pkg::WIN_TUKEY: win_class = fwm_pkg::CLASS_TUKEY;
            default:            win_class = fwm_pkg::CLASS_RECT;
        endcase
        n_terms = fwm_pkg::win_terms(wtype_reg);
    end

    // Cosine-sum phase: (8192*k*n + N) / (2N)
    assign kn      = 15'(k_reg) * 15'(n_reg);
    assign cos_dvd = (fwm_pkg::dvd_t'(kn) << 13) + fwm_pkg::dvd_t'(eff_n);
    assign cos_dvs = fwm_pkg::dvs_t'(eff_n) << 1;

    // Tukey taper region and phase: (2^29*d + N*a) / (2*N*a)
    assign np        = fwm_pkg::den_t'(n_reg) << 17;
    assign flat_lim  = (fwm_pkg::dvs_t'(eff_n) << 17) - fwm_pkg::dvs_t'(den_reg);
    assign tuk_first = (np < den_reg);
    assign tuk_flat  = (alpha_c == '0) || (!tuk_first && (fwm_pkg::dvs_t'(np) <= flat_lim));
    assign tuk_d     = tuk_first ? fwm_pkg::nsz_t'(n_reg) : (eff_n - fwm_pkg::nsz_t'(n_reg));
    assign tuk_dvd   = (fwm_pkg::dvd_t'(tuk_d) << 29) + fwm_pkg::dvd_t'(den_reg);
    assign tuk_dvs   = fwm_pkg::dvs_t'(den_reg) << 1;

    assign div_start = cmd.div_cos | cmd.tuk_div;

    fwm_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cmd.tuk_div ? tuk_dvd : cos_dvd),
        .divisor  (cmd.tuk_div ? tuk_dvs : cos_dvs),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quotient)
    );

    // Select the table phase: zero for the constant term, half a turn added for Tukey
    assign rom_en    = cmd.rom_zero | cmd.rom_from_q;
    assign rom_phase = cmd.rom_zero ? '0
                     : (win_class == fwm_pkg::CLASS_TUKEY)
                       ? (fwm_pkg::turn_t'(quotient) + fwm_pkg::turn_t'(2 * fwm_pkg::COS_DEPTH))
                       : fwm_pkg::turn_t'(quotient);

    fwm_cos_rom u_rom (
        .clk     (clk),
        .rd_en   (rom_en),
        .phase   (rom_phase),
        .cos_val (cos_val)
    );

    // Round and saturate the output product
    assign rnd = (oprod_reg + fwm_pkg::oprod_t'(32768)) >>> 16;
    always_comb
    begin
        if (rnd > SAT_MAX)
        begin
            sat = fwm_pkg::samp_t'(SAT_MAX);
        end
        else if (rnd < SAT_MIN)
        begin
            sat = fwm_pkg::samp_t'(SAT_MIN);
        end
        else
        begin
            sat = fwm_pkg::samp_t'(rnd);
        end
    end

    assign out_free = !out_valid_reg || out_ready;
    assign last_pos = (fwm_pkg::nsz_t'(n_reg) == (eff_n - fwm_pkg::nsz_t'(1)));
    assign n_inc    = fwm_pkg::nsz_t'(n_reg) + fwm_pkg::nsz_t'(1);

    // Control registers: configuration, position, term counter, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wtype_reg     <= fwm_pkg::WIN_HANN;
            fsize_reg     <= fwm_pkg::nsz_t'(1024);
            alpha_reg     <= fwm_pkg::alpha_t'(32768);
            pos_reg       <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (cfg_index)
                    fwm_pkg::REG_WINDOW_TYPE: wtype_reg <= fwm_pkg::win_t'(cfg_data);
                    fwm_pkg::REG_FRAME_SIZE:  fsize_reg <= fwm_pkg::nsz_t'(cfg_data);
                    fwm_pkg::REG_TUKEY_ALPHA: alpha_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.accept)
            begin
                k_reg <= '0;
            end
            else if (cmd.acc)
            begin
                k_reg <= k_reg + 3'd1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
                pos_reg       <= (n_inc >= eff_n) ? '0 : fwm_pkg::pos_t'(n_inc);
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            samp_reg <= sample;
            n_reg    <= (fwm_pkg::nsz_t'(pos_reg) >= eff_n) ? '0 : pos_reg;
            acc_reg  <= '0;
        end
        if (cmd.mul)
        begin
            prod_reg <= fwm_pkg::prod_t'($signed({1'b0, fwm_pkg::win_coef(wtype_reg, k_reg)}))
                      * fwm_pkg::prod_t'(cos_val);
        end
        if (cmd.acc)
        begin
            acc_reg <= k_reg[0] ? (acc_reg - fwm_pkg::acc_t'(prod_reg))
                                : (acc_reg + fwm_pkg::acc_t'(prod_reg));
        end
        if (cmd.tuk_prep)
        begin
            den_reg <= fwm_pkg::den_t'(alpha_c) * fwm_pkg::den_t'(eff_n);
        end
        if (cmd.cos_w)
        begin
            w_reg <= fwm_pkg::weight_t'((acc_reg + fwm_pkg::acc_t'(536870912)) >>> 30);
        end
        else if (cmd.tuk_w)
        begin
            w_reg <= (fwm_pkg::weight_t'(fwm_pkg::ONE_Q16 + 1) + fwm_pkg::weight_t'(cos_val)) >>> 1;
        end
        else if (cmd.one_w)
        begin
            w_reg <= fwm_pkg::weight_t'(fwm_pkg::ONE_Q16);
        end
        if (cmd.out_mul)
        begin
            oprod_reg <= fwm_pkg::oprod_t'(samp_reg) * fwm_pkg::oprod_t'(w_reg);
        end
        if (cmd.out_load)
        begin
            out_sample_reg <= sat;
            out_last_reg   <= last_pos;
        end
    end

    // Status toward the sequencer
    always_comb
    begin
        sts.win_class = win_class;
        sts.k_zero    = (k_reg == '0);
        sts.k_last    = (k_reg == (n_terms - 3'd1));
        sts.div_done  = div_done;
        sts.div_busy  = div_busy;
        sts.tuk_flat  = tuk_flat;
        sts.out_free  = out_free;
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign out_last   = out_last_reg;

endmodule

`default_nettype wire

>>> rtl/core/frame_window_multiplier_top.sv
// Frame window multiplier: one sample in, one windowed sample out, sequenced over
// a 14-step phase divider, a registered cosine ROM and a coefficient MAC.
// Rectangular windows and the flat part of the Tukey taper skip the divider; each
// cosine term past the first runs it once. One sample is in work at a time; the result
// turns valid in the same cycle as the next sample can be taken, and waits on ready.
// Reset restores window type 1, frame size 1024, alpha 0.5 and frame position 0.
`default_nettype none

module frame_window_multiplier_top (
    input  wire logic    clk,
    input  wire logic    rst_n,
    fwm_sample_if.sink   samples,
    fwm_result_if.source results,
    fwm_cfg_if.sink      cfg
);

    fwm_pkg::fwm_cmd_t cmd;
    fwm_pkg::fwm_sts_t sts;
    logic              in_ready;

    assign samples.ready = in_ready;
    assign cfg.ready     = 1'b1;

    fwm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fwm_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .sample     (samples.sample),
        .cfg_wr     (cfg.valid),
        .cfg_index  (cfg.index),
        .cfg_data   (cfg.data),
        .out_valid  (results.valid),
        .out_ready  (results.ready),
        .out_sample (results.windowed_sample),
        .out_last   (results.last_of_frame)
    );

    // Start the divider only when it is free
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_cos || cmd.tuk_div) |-> !sts.div_busy)
        else $error("divider started while busy");

    // Load a result only into a free output register
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result overwritten before delivery");

    // Drop ready after a sample is taken
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (samples.valid && samples.ready) |=> !samples.ready)
        else $error("second sample accepted while busy");

    // Select at most one weight source
    a_weight_sel: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.cos_w, cmd.tuk_w, cmd.one_w}))
        else $error("conflicting weight loads");

endmodule

`default_nettype wire
